### design/sha1_pkg.sv
`timescale 1ns / 1ps
package sha1_pkg;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    // datapath commands from the controller
    typedef struct packed {
        logic       put;       // write one byte into the buffer
        logic [7:0] put_byte;
        logic       add_bits;  // count a message byte
        logic       start;     // begin compression
        logic       round;     // run one round
        logic       finish;    // add working vars into chain
        logic       init;      // return to initial hash state
    } t_cmd;

    typedef struct packed {
        logic [5:0]  pos;
        logic [63:0] bits;
    } t_stat;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        if (t < 7'd20) return 32'h5a827999;
        else if (t < 7'd40) return 32'h6ed9eba1;
        else if (t < 7'd60) return 32'h8f1bbcdc;
        else return 32'hca62c1d6;
    endfunction
endpackage

### design/sha1_if.sv
`timescale 1ns / 1ps
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    modport source (output valid, data_byte, byte_valid, message_end, input ready);
    modport sink (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### design/sha1_datapath.sv
`timescale 1ns / 1ps
module sha1_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1_pkg::t_cmd      i_cmd,
    input  logic [2:0]          i_sel,
    output sha1_pkg::t_stat     o_stat,
    output logic [31:0]         o_chain
);
    logic [31:0] r_chain [5];
    logic [31:0] r_buf [16];
    logic [31:0] r_win [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_t;
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [31:0] w, f, s, n_a;
    logic [31:0] byte_word;

    always_comb begin
        s = r_win[(r_t[3:0] - 4'd3)] ^ r_win[(r_t[3:0] - 4'd8)]
          ^ r_win[(r_t[3:0] - 4'd14)] ^ r_win[r_t[3:0]];
        w = (r_t < 7'd16) ? r_buf[r_t[3:0]] : {s[30:0], s[31]};
        if (r_t < 7'd20) f = (r_b & r_c) | (~r_b & r_d);
        else if (r_t < 7'd40 || r_t >= 7'd60) f = r_b ^ r_c ^ r_d;
        else f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
        n_a = {r_a[26:0], r_a[31:27]} + f + r_e + sha1_pkg::round_k(r_t) + w;
        byte_word = {24'd0, i_cmd.put_byte} << {(2'd3 - r_pos[1:0]), 3'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_chain[0] <= sha1_pkg::H0; r_chain[1] <= sha1_pkg::H1;
            r_chain[2] <= sha1_pkg::H2; r_chain[3] <= sha1_pkg::H3;
            r_chain[4] <= sha1_pkg::H4;
            r_pos <= '0; r_bits <= '0;
        end else begin
            if (i_cmd.add_bits) r_bits <= r_bits + 64'd8;
            if (i_cmd.put) begin
                r_pos <= r_pos + 6'd1;
                if (r_pos[1:0] == 2'd0) r_buf[r_pos[5:2]] <= byte_word;
                else r_buf[r_pos[5:2]] <= r_buf[r_pos[5:2]] | byte_word;
            end
            if (i_cmd.finish) begin
                r_chain[0] <= r_chain[0] + r_a; r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c; r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
        end
        if (i_cmd.start) begin
            r_a <= r_chain[0]; r_b <= r_chain[1]; r_c <= r_chain[2];
            r_d <= r_chain[3]; r_e <= r_chain[4]; r_t <= '0;
        end else if (i_cmd.round) begin
            r_win[r_t[3:0]] <= w;
            r_a <= n_a; r_b <= r_a; r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c; r_e <= r_d; r_t <= r_t + 7'd1;
        end
    end

    assign o_stat.pos = r_pos;
    assign o_stat.bits = r_bits;
    assign o_chain = r_chain[i_sel];
endmodule

### design/sha1_ctrl.sv
`timescale 1ns / 1ps
module sha1_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1_in_if.sink         in_if,
    sha1_out_if.source      out_if,
    input  sha1_pkg::t_stat i_stat,
    input  logic [31:0]     i_chain,
    output sha1_pkg::t_cmd  o_cmd,
    output logic [2:0]      o_sel
);
    typedef enum logic [2:0] {S_IDLE, S_ROUND, S_FIN, S_PAD, S_LEN, S_OUT} t_state;
    t_state r_state;
    logic   r_end;      // padding pending after this compression
    logic   r_padding;  // in pad phase when compression returns
    logic   r_lenmode;
    logic [2:0] r_lcnt;
    logic [63:0] r_len;
    logic [2:0] r_idx;
    logic [6:0] r_rc;
    logic accept;

    assign accept = in_if.valid && in_if.ready;
    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = (r_state == S_OUT);
    assign out_if.digest_word = i_chain;
    assign out_if.word_index = r_idx;
    assign out_if.last_word = (r_idx == 3'd4);
    assign o_sel = r_idx;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.put = accept && in_if.byte_valid;
                o_cmd.add_bits = o_cmd.put;
                o_cmd.put_byte = in_if.data_byte;
                o_cmd.start = o_cmd.put && (i_stat.pos == 6'd63);
            end
            S_ROUND: o_cmd.round = 1'b1;
            S_FIN: o_cmd.finish = 1'b1;
            S_PAD: begin
                o_cmd.put = 1'b1;
                o_cmd.put_byte = r_padding ? 8'h00 : sha1_pkg::PAD_BYTE;
                o_cmd.start = (i_stat.pos == 6'd63);
            end
            S_LEN: begin
                o_cmd.put = 1'b1;
                o_cmd.put_byte = r_len[63:56];
                o_cmd.start = (i_stat.pos == 6'd63);
            end
            S_OUT: o_cmd.init = out_if.ready && (r_idx == 3'd4);
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_end <= 1'b0; r_padding <= 1'b0;
            r_idx <= '0; r_rc <= '0; r_lenmode <= 1'b0; r_lcnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_padding <= 1'b0;
                    r_len <= i_stat.bits + (in_if.byte_valid ? 64'd8 : 64'd0);
                    r_end <= in_if.message_end;
                    if (o_cmd.start) begin
                        r_state <= S_ROUND; r_rc <= '0;
                    end else if (in_if.message_end) r_state <= S_PAD;
                end
                S_ROUND: begin
                    r_rc <= r_rc + 7'd1;
                    if (r_rc == 7'd79) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_end) r_state <= S_IDLE;
                    else if (r_lenmode) begin
                        r_state <= S_OUT; r_idx <= '0; r_lenmode <= 1'b0;
                    end else r_state <= S_PAD;
                end
                S_PAD: begin
                    r_padding <= 1'b1;
                    if (o_cmd.start) begin
                        r_state <= S_ROUND; r_rc <= '0;
                    end else if (i_stat.pos == sha1_pkg::LENGTH_POS - 6'd1) begin
                        r_state <= S_LEN; r_lcnt <= '0;
                    end
                end
                S_LEN: begin
                    r_len <= {r_len[55:0], 8'h00};
                    r_lcnt <= r_lcnt + 3'd1;
                    if (r_lcnt == 3'd7) begin
                        r_state <= S_ROUND; r_rc <= '0; r_lenmode <= 1'b1;
                    end
                end
                S_OUT: if (out_if.ready) begin
                    r_idx <= (r_idx == 3'd4) ? 3'd0 : r_idx + 3'd1;
                    if (r_idx == 3'd4) begin
                        r_state <= S_IDLE; r_end <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### design/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// a byte that fills a block starts a compression: intake, 80 rounds one per cycle, fold
// other bytes are taken one per cycle while idle; message end: padding one byte per cycle, one or two
// compressions, then five digest words, one per cycle when the sink is ready
// throughput is bound by the single round unit: no byte is taken while a 64-byte block is compressed
// reset: synchronous active low, loads the initial hash state and clears counts
module sha1_message_digest_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha1_in_if.sink    in_if,
    sha1_out_if.source out_if
);
    sha1_pkg::t_cmd  cmd;
    sha1_pkg::t_stat stat;
    logic [31:0]     chain;
    logic [2:0]      sel;

    // controller sequences byte intake, padding, rounds and digest output
    sha1_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(in_if), .out_if(out_if),
        .i_stat(stat), .i_chain(chain), .o_cmd(cmd), .o_sel(sel)
    );

    // datapath holds buffer, schedule window, working and chaining words
    sha1_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_sel(sel),
        .o_stat(stat), .o_chain(chain)
    );

    // no intake while a word is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> !in_if.ready) else $error("intake during output");
    // after the last word the hash state is reinitialized
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_if.valid && out_if.ready && out_if.last_word) |=> (stat.pos == 6'd0))
        else $error("no reinit");
    // word index stays in range
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> (out_if.word_index <= 3'd4)) else $error("bad index");
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest;

    // running sha-1 state plus the queue of digest words still owed
    class digest_board;
        logic [31:0] chain [5];
        logic [31:0] blk [16];
        logic [5:0]  fill;
        logic [63:0] nbits;
        t_digest     owed [$];
        int          errors;

        function void restart();
            chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
            chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
            fill = '0;
            nbits = '0;
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, t2, wt;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 16) begin
                    wt = w[t];
                end else begin
                    wt = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
                    wt = {wt[30:0], wt[31]};
                    w[t & 15] = wt;
                end
                if (t < 20) begin
                    f = (b & c) | (~b & d); k = 32'h5a827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d; k = 32'h6ed9eba1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
                end else begin
                    f = b ^ c ^ d; k = 32'hca62c1d6;
                end
                t2 = {a[26:0], a[31:27]} + f + e + k + wt;
                e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void absorb(logic [7:0] byt);
            logic [31:0] sh;
            sh = 32'(byt) << (8 * (3 - fill[1:0]));
            if (fill[1:0] == 2'd0) blk[fill[5:2]] = sh;
            else blk[fill[5:2]] |= sh;
            if (fill == 6'd63) compress();
            fill = fill + 6'd1;
        endfunction

        function void note_word(logic [7:0] byt, logic bv, logic me);
            logic [63:0] len;
            t_digest r;
            if (bv) begin
                nbits += 64'd8;
                absorb(byt);
            end
            if (!me) return;
            len = nbits;
            absorb(sha1_pkg::PAD_BYTE);
            while (fill != sha1_pkg::LENGTH_POS) absorb(8'h00);
            for (int i = 0; i < 8; i++) absorb(len[63 - 8 * i -: 8]);
            for (int i = 0; i < 5; i++) begin
                r.digest_word = chain[i];
                r.word_index = 3'(i);
                r.last_word = (i == 4);
                owed.push_back(r);
            end
            restart();
        endfunction

        function void check_word(t_digest got);
            t_digest exp;
            if (owed.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, got);
                errors++;
                return;
            end
            exp = owed.pop_front();
            if (got.digest_word !== exp.digest_word) begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         exp.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== exp.word_index) begin
                $display("%0t: word_index expected %0d actual %0d", $time,
                         exp.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== exp.last_word) begin
                $display("%0t: last_word expected %0d actual %0d", $time,
                         exp.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    sha1_in_if  in_if ();
    sha1_out_if out_if ();

    sha1_message_digest_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (in_if.sink),
        .out_if  (out_if.source)
    );

    digest_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    bit timed_out;
    localparam int QUIET_LIMIT = 20000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, checks each accepted digest word
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_word({out_if.digest_word, out_if.word_index, out_if.last_word});
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("sha1_message_digest_unit test failed");
            $finish;
        end
    end

    task automatic send_word(logic [7:0] byt, logic bv, logic me);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= byt;
        in_if.byte_valid <= bv;
        in_if.message_end <= me;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.note_word(byt, bv, me);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len - 1; i++)
            send_word(8'($urandom), 1'b1, 1'b0);
        if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
        else send_word(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int lens [3];
        board = new();
        board.restart();
        board.errors = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.byte_valid = 1'b0;
        in_if.message_end = 1'b0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, idle item, extreme bytes
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'h33, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        // pause until every digest word is back
        drain();

        // random messages; lengths around 55/56/64 hit padding edges
        lens = '{55, 56, 64};
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 29 : 0;
            send_message(lens[phase]);
            for (int m = 0; m < 2; m++) begin
                if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
                send_message($urandom_range(7));
            end
            drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("sha1_message_digest_unit test passed");
        else
            $display("sha1_message_digest_unit test failed");
        $finish;
    end
endmodule
